### design/tts_pkg.sv
// Shared types, codes and defaults for the tick task scheduler.
`default_nettype none

package tts_pkg;

	// default number of task slots
	localparam int TASK_SLOTS_DEF = 16;

	localparam int HANDLE_W = 31;
	localparam int TICK_W   = 64;
	localparam int PERIOD_W = 32;

	// command codes
	localparam logic [2:0] CMD_TICK     = 3'd0;
	localparam logic [2:0] CMD_NEXT     = 3'd1;
	localparam logic [2:0] CMD_TIMEOUT  = 3'd2;
	localparam logic [2:0] CMD_INTERVAL = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_ASSIGNED = 2'd0;
	localparam logic [1:0] KIND_FIRED    = 2'd1;
	localparam logic [1:0] KIND_FULL     = 2'd2;
	localparam logic [1:0] KIND_DONE     = 2'd3;

	// one timer entry as held by a cell
	typedef struct packed {
		logic                used;
		logic [HANDLE_W-1:0] handle;
		logic [TICK_W-1:0]   due;
		logic [PERIOD_W-1:0] period;
	} entry_t;

	// what the row of cells does this cycle
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_ROTATE,
		OP_COMPACT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   new_entry;
	} cell_ctrl_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_COMPACT
	} state_t;

endpackage

`default_nettype wire

### design/tts_cell.sv
// One slot of the timer table: holds an entry, loads a new one when selected and takes its neighbor's on a shift.
`default_nettype none

module tts_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tts_pkg::cell_ctrl_t ctrl,
	input  wire logic               load_sel,
	input  wire tts_pkg::entry_t    nbr_in,
	input  wire logic               hole_in,
	output logic                    hole_out,
	output tts_pkg::entry_t         entry
);
	import tts_pkg::*;

	logic                used_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TICK_W-1:0]   due_q;
	logic [PERIOD_W-1:0] period_q;
	logic                take_nbr;
	logic                take_new;

	// a free slot here or below pulls the upper part of the row down
	assign hole_out = hole_in | ~used_q;

	always_comb begin
		take_nbr = 1'b0;
		take_new = 1'b0;
		case (ctrl.op)
			OP_LOAD:    take_new = load_sel;
			OP_ROTATE:  take_nbr = 1'b1;
			OP_COMPACT: take_nbr = hole_out;
			default:    ;
		endcase
	end

	// used flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (take_new) begin
			used_q <= 1'b1;
		end else if (take_nbr) begin
			used_q <= nbr_in.used;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take_new) begin
			handle_q <= ctrl.new_entry.handle;
			due_q    <= ctrl.new_entry.due;
			period_q <= ctrl.new_entry.period;
		end else if (take_nbr) begin
			handle_q <= nbr_in.handle;
			due_q    <= nbr_in.due;
			period_q <= nbr_in.period;
		end
	end

	assign entry = '{used: used_q, handle: handle_q, due: due_q, period: period_q};

endmodule

`default_nettype wire

### design/tick_task_scheduler_core.sv
// Top level of the tick task scheduler: sequencer, counters and the row of slot cells.
//
//  channel   | signals                                      | direction
//  ----------+----------------------------------------------+----------
//  request   | start, command, tick_value, delay,           | in
//            | target_handle; busy                          | in; busy out
//  result    | strobe, kind, handle, last                   | out
//
// Schedule and unknown commands are handled in idle; the registered result appears the cycle after.
// Tick and clear rotate the row once (head slot inspected each cycle, fired tasks
// reported one per cycle), then compact it, with busy high throughout.
// Reset empties the table, zeroes the last tick and sets the next handle to one.
// Results are shown for one cycle each; the receiver cannot stall.
`default_nettype none

module tick_task_scheduler_core #(
	parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [63:0] tick_value,
	input  wire logic [31:0] delay,
	input  wire logic [30:0] target_handle,
	output logic             strobe,
	output logic [1:0]       kind,
	output logic [30:0]      handle,
	output logic             last
);
	import tts_pkg::*;

	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    fill_q;
	logic [TICK_W-1:0]   last_tick_q;
	logic [TICK_W-1:0]   tick_q;
	logic [HANDLE_W-1:0] target_q;
	logic                mode_tick_q;
	logic [HANDLE_W-1:0] hcount_q;

	logic                accept;
	logic                cnt_end;
	logic                full;
	logic [PERIOD_W-1:0] d_eff;
	cell_ctrl_t          ctrl;
	entry_t              head;
	entry_t              tail_in;
	logic                fire;
	logic                drop;

	logic                strobe_d;
	logic [1:0]          kind_d;
	logic [HANDLE_W-1:0] handle_d;
	logic                last_d;

	entry_t              cells[TASK_SLOTS];
	logic [TASK_SLOTS:0] hole;
	logic [TASK_SLOTS-1:0] load_sel;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start & ~busy;
	assign cnt_end = (cnt_q == CNT_W'(TASK_SLOTS - 1));
	assign full    = (fill_q == CNT_W'(TASK_SLOTS));
	assign d_eff   = (command == CMD_NEXT || delay == '0) ? PERIOD_W'(1) : delay;

	// head slot inspection during rotation
	assign head = cells[0];
	assign fire = mode_tick_q & head.used & (head.due <= tick_q);
	assign drop = head.used & (mode_tick_q ? (fire & (head.period == '0))
	                                       : (head.handle == target_q));

	always_comb begin
		tail_in = head;
		if (state_q == ST_ROTATE) begin
			if (drop) begin
				tail_in.used = 1'b0;
			end else if (fire) begin
				tail_in.due = tick_q + TICK_W'(head.period);
			end
		end else begin
			tail_in.used = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (command == CMD_TICK || command == CMD_CLEAR)) begin
					state_d = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				if (cnt_end) begin
					state_d = ST_COMPACT;
				end
			end
			ST_COMPACT: begin
				if (cnt_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// cell control and result generation
	always_comb begin
		ctrl.op               = OP_HOLD;
		ctrl.new_entry.used   = 1'b1;
		ctrl.new_entry.handle = hcount_q;
		ctrl.new_entry.due    = last_tick_q + TICK_W'(d_eff);
		ctrl.new_entry.period = (command == CMD_INTERVAL) ? d_eff : '0;
		strobe_d = 1'b0;
		kind_d   = KIND_DONE;
		handle_d = '0;
		last_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command) inside
						CMD_TICK, CMD_CLEAR: ;
						CMD_NEXT, CMD_TIMEOUT, CMD_INTERVAL: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
							if (full) begin
								kind_d = KIND_FULL;
							end else begin
								ctrl.op  = OP_LOAD;
								kind_d   = KIND_ASSIGNED;
								handle_d = hcount_q;
							end
						end
						default: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
						end
					endcase
				end
			end
			ST_ROTATE: begin
				ctrl.op = OP_ROTATE;
				if (fire) begin
					strobe_d = 1'b1;
					kind_d   = KIND_FIRED;
					handle_d = head.handle;
				end
			end
			ST_COMPACT: begin
				ctrl.op = OP_COMPACT;
				if (cnt_end) begin
					strobe_d = 1'b1;
					last_d   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			last_tick_q <= '0;
			hcount_q    <= HANDLE_W'(1);
			strobe      <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= strobe_d;
			if (state_q == ST_IDLE || cnt_end) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctrl.op == OP_LOAD) begin
				fill_q   <= fill_q + CNT_W'(1);
				hcount_q <= hcount_q + HANDLE_W'(1);
			end else if (state_q == ST_ROTATE && drop) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (accept && command == CMD_TICK) begin
				last_tick_q <= tick_value;
			end
		end
	end

	// request operands held through a tick or clear
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q      <= tick_value;
			target_q    <= target_handle;
			mode_tick_q <= (command == CMD_TICK);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		kind   <= kind_d;
		handle <= handle_d;
		last   <= last_d;
	end

	// row of slot cells, cell 0 at the head
	assign hole[0] = 1'b0;

	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		entry_t nbr;

		if (i == TASK_SLOTS - 1) begin : g_tail
			assign nbr = tail_in;
		end else begin : g_mid
			assign nbr = cells[i+1];
		end

		assign load_sel[i] = (fill_q == CNT_W'(i));

		tts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load_sel (load_sel[i]),
			.nbr_in   (nbr),
			.hole_in  (hole[i]),
			.hole_out (hole[i+1]),
			.entry    (cells[i])
		);
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TASK_SLOTS))
		else $error("fill count exceeds table size");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("final result while still busy");

	a_fired_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && kind == KIND_FIRED)
		else $error("non-final result outside a tick");

	a_load_space: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_LOAD |-> !full)
		else $error("load into a full table");
`endif

endmodule

`default_nettype wire
